@@ sv/dsc_pkg.sv @@
// shared constants, types and the arctangent table of the segment classifier
package dsc_pkg;

  localparam int NUM_WEDGES   = 6;
  localparam int PHI_W        = 15;
  localparam int ANG_W        = 16;
  localparam int CRD_W        = 21;
  localparam int CORDIC_STEPS = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int BOUND_W      = 16;

  localparam logic signed [ANG_W-1:0] PI_FX = 16'sd12868;

  // boundary register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHI_BOUND_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_BOUND_5 = 3'd5;

  // operation codes
  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [BOUND_W-1:0] bound_t;

  function automatic ang_t atan_angle(input int i);
    ang_t r;
    case (i)
      0:       r = 16'sd3217;
      1:       r = 16'sd1899;
      2:       r = 16'sd1003;
      3:       r = 16'sd509;
      4:       r = 16'sd256;
      5:       r = 16'sd128;
      6:       r = 16'sd64;
      7:       r = 16'sd32;
      8:       r = 16'sd16;
      9:       r = 16'sd8;
      10:      r = 16'sd4;
      11:      r = 16'sd2;
      12:      r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/dsc_cordic_stage.sv @@
// registered group of cordic vectoring iterations
module dsc_cordic_stage #(
  parameter int FIRST = 0,
  parameter int STEPS = 4
) (
  input  logic           clk,
  input  logic           en,
  input  dsc_pkg::crd_t  x_in,
  input  dsc_pkg::crd_t  y_in,
  input  dsc_pkg::ang_t  a_in,
  output dsc_pkg::crd_t  x_out,
  output dsc_pkg::crd_t  y_out,
  output dsc_pkg::ang_t  a_out
);
  import dsc_pkg::*;

  crd_t x_next, y_next;
  ang_t a_next;

  always_comb begin
    crd_t xc, yc, xt, yt;
    ang_t ac;
    xc = x_in;
    yc = y_in;
    ac = a_in;
    for (int i = FIRST; i < FIRST + STEPS; i++) begin
      if (yc < 0) begin
        xt = xc - (yc >>> i);
        yt = yc + (xc >>> i);
        ac = ac - atan_angle(i);
      end else begin
        xt = xc + (yc >>> i);
        yt = yc - (xc >>> i);
        ac = ac + atan_angle(i);
      end
      xc = xt;
      yc = yt;
    end
    x_next = xc;
    y_next = yc;
    a_next = ac;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      a_out <= a_next;
    end
  end

endmodule

@@ sv/dsc_bound_ram.sv @@
// one bank of layer boundary words, one write and one registered read sharing one address port
module dsc_bound_ram #(
  parameter int DEPTH = 2500,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       addr,
  input  dsc_pkg::bound_t     wdata,
  input  logic                re,
  output dsc_pkg::bound_t     rdata
);
  import dsc_pkg::*;

  bound_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ sv/detector_segment_classifier_unit.sv @@
// segment classifier top level: azimuth wedge and depth layer of a detector point
// each beat is registered through stages 0 to 4, stage 4 holding the result beat
// throughput: one beat per cycle unless out_stall holds a result, loads and points mixed freely
// the pipeline freezes as a whole only while a result waits under out_stall
// rst clears valid bits and boundary angles; the boundary table is not cleared
module detector_segment_classifier_unit #(
  parameter int GRID_CELLS   = 50,
  parameter int LAYER_BOUNDS = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsc_pkg::PHI_W-1:0]       cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic signed [14:0]              x,
  input  logic signed [14:0]              y,
  input  logic [14:0]                     z,
  input  logic [5:0]                      cell_x,
  input  logic [5:0]                      cell_y,
  input  logic [2:0]                      boundary_index,
  input  logic signed [15:0]              boundary_z,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      wedge,
  output logic                            wedge_found,
  output logic [2:0]                      layer,
  output logic                            layer_found,
  output logic [5:0]                      segment
);
  import dsc_pkg::*;

  localparam int CW    = $clog2(GRID_CELLS);
  localparam int DEPTH = GRID_CELLS * GRID_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(LAYER_BOUNDS + 1);

  // whole pipeline moves unless the result beat is held back
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // boundary angle registers
  logic signed [PHI_W-1:0] phi_bound [NUM_WEDGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEDGES; i++) phi_bound[i] <= '0;
    end else if (cfg_we && cfg_index <= REG_PHI_BOUND_5) begin
      phi_bound[cfg_index] <= cfg_data;
    end
  end

  // stage 0: input register
  logic                 v0, func0;
  logic signed [14:0]   x0, y0;
  logic [14:0]          z0;
  logic [5:0]           cx0, cy0;
  logic [2:0]           bi0;
  bound_t               bz0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func0 <= func;
      x0    <= x;
      y0    <= y;
      z0    <= z;
      cx0   <= cell_x;
      cy0   <= cell_y;
      bi0   <= boundary_index;
      bz0   <= boundary_z;
    end
  end

  // grid cell of a coordinate, clamped to the grid
  function automatic logic [CW-1:0] grid_cell(input logic signed [14:0] c);
    logic signed [17:0] v;
    logic [8:0]         sh;
    logic [CW-1:0]      r;
    v  = {{3{c[14]}}, c} + 18'(GRID_CELLS * 256);
    sh = {1'b0, v[16:9]};
    if (v[17]) r = '0;
    else if (sh > 9'(GRID_CELLS - 1)) r = CW'(GRID_CELLS - 1);
    else r = CW'(sh);
    return r;
  endfunction

  // stage 0 logic: quadrant fold, scaling, table address
  crd_t          xs0, ys0;
  ang_t          as0;
  logic          zero0, wr_ok0;
  logic [CW-1:0] gx0, gy0;
  logic [AW-1:0] addr0;

  always_comb begin
    crd_t xe, ye;
    xe = {{(CRD_W-15){x0[14]}}, x0};
    ye = {{(CRD_W-15){y0[14]}}, y0};
    if (x0 < 0) begin
      xs0 = (-xe) <<< 3;
      ys0 = (-ye) <<< 3;
      as0 = (y0 >= 0) ? PI_FX : -PI_FX;
    end else begin
      xs0 = xe <<< 3;
      ys0 = ye <<< 3;
      as0 = '0;
    end
    zero0 = (x0 == '0) && (y0 == '0);
    gx0   = grid_cell(x0);
    gy0   = grid_cell(y0);
    if (func0 == FUNC_CLASSIFY) begin
      addr0 = AW'(int'(gx0) * GRID_CELLS + int'(gy0));
    end else begin
      addr0 = AW'(int'(cx0) * GRID_CELLS + int'(cy0));
    end
    wr_ok0 = (func0 == FUNC_LOAD) && ({3'b0, cx0} < 9'(GRID_CELLS))
             && ({3'b0, cy0} < 9'(GRID_CELLS)) && ({1'b0, bi0} < 4'(LAYER_BOUNDS));
  end

  // stage 1: first four iterations, table access
  crd_t          x1, y1;
  ang_t          a1;
  logic          v1, func1, zero1, wr_ok1;
  logic [14:0]   z1;
  logic [AW-1:0] addr1;
  logic [2:0]    bi1;
  bound_t        bz1;

  dsc_cordic_stage #(.FIRST(0), .STEPS(4)) u_crd0 (
    .clk(clk), .en(adv), .x_in(xs0), .y_in(ys0), .a_in(as0),
    .x_out(x1), .y_out(y1), .a_out(a1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1  <= func0;
      zero1  <= zero0;
      wr_ok1 <= wr_ok0;
      z1     <= z0;
      addr1  <= addr0;
      bi1    <= bi0;
      bz1    <= bz0;
    end
  end

  // boundary banks, one per boundary index; write and read in the same stage keep order
  bound_t bnd2 [LAYER_BOUNDS];

  for (genvar k = 0; k < LAYER_BOUNDS; k++) begin : g_bank
    dsc_bound_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clk   (clk),
      .we    (v1 && adv && wr_ok1 && (bi1 == 3'(k))),
      .addr  (addr1),
      .wdata (bz1),
      .re    (adv),
      .rdata (bnd2[k])
    );
  end

  // stage 2: next four iterations, layer search
  crd_t        x2, y2;
  ang_t        a2;
  logic        v2, func2, zero2;
  logic [14:0] z2;

  dsc_cordic_stage #(.FIRST(4), .STEPS(4)) u_crd1 (
    .clk(clk), .en(adv), .x_in(x1), .y_in(y1), .a_in(a1),
    .x_out(x2), .y_out(y2), .a_out(a2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func2 <= func1;
      zero2 <= zero1;
      z2    <= z1;
    end
  end

  logic [LW-1:0] lay2;
  logic          lf2;

  always_comb begin
    logic signed [16:0] zz;
    logic signed [16:0] bb [LAYER_BOUNDS];
    zz = {2'b0, z2};
    for (int k = 0; k < LAYER_BOUNDS; k++) bb[k] = {bnd2[k][15], bnd2[k]};
    lay2 = '0;
    lf2  = 1'b0;
    if (zz <= bb[0]) begin
      lf2 = 1'b1;
    end else begin
      for (int k = 1; k < LAYER_BOUNDS; k++) begin
        if (!lf2 && zz <= bb[k] && zz > bb[k-1]) begin
          lay2 = LW'(k);
          lf2  = 1'b1;
        end
      end
      if (!lf2 && zz > bb[LAYER_BOUNDS-1]) begin
        lay2 = LW'(LAYER_BOUNDS);
        lf2  = 1'b1;
      end
    end
  end

  // stage 3: last five iterations, layer result held
  ang_t          a3;
  logic          v3, func3, zero3, lf3;
  logic [LW-1:0] lay3;

  dsc_cordic_stage #(.FIRST(8), .STEPS(CORDIC_STEPS - 8)) u_crd2 (
    .clk(clk), .en(adv), .x_in(x2), .y_in(y2), .a_in(a2),
    .x_out(), .y_out(), .a_out(a3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func3 <= func2;
      zero3 <= zero2;
      lf3   <= lf2;
      lay3  <= lay2;
    end
  end

  // wedge between upper boundary hi and lower boundary lo, with wrap at +-pi
  function automatic logic wedge_rule(input ang_t phi, input logic signed [PHI_W-1:0] hi,
                                      input logic signed [PHI_W-1:0] lo);
    logic same, opp;
    same = (hi > 0 && lo > 0) || (hi < 0 && lo < 0);
    opp  = (hi > 0 && lo < 0) || (hi < 0 && lo > 0);
    return (same && phi <= hi && phi > lo) || (opp && (phi <= hi || phi > lo));
  endfunction

  // stage 3 logic: clamp, wedge priority, segment
  logic [2:0] wedge3, layer3;
  logic       wf3, lfo3;
  logic [5:0] seg3;

  always_comb begin
    ang_t       phi;
    logic [6:0] s;
    if (zero3) phi = '0;
    else if (a3 > PI_FX) phi = PI_FX;
    else if (a3 < -PI_FX) phi = -PI_FX;
    else phi = a3;
    wedge3 = 3'd0;
    wf3    = 1'b1;
    // rules tried from wedge 3 downward, then wedge 5 and wedge 4
    if (wedge_rule(phi, phi_bound[2], phi_bound[3])) wedge3 = 3'd3;
    else if (wedge_rule(phi, phi_bound[1], phi_bound[2])) wedge3 = 3'd2;
    else if (wedge_rule(phi, phi_bound[0], phi_bound[1])) wedge3 = 3'd1;
    else if (wedge_rule(phi, phi_bound[5], phi_bound[0])) wedge3 = 3'd0;
    else if (wedge_rule(phi, phi_bound[4], phi_bound[5])) wedge3 = 3'd5;
    else if (wedge_rule(phi, phi_bound[3], phi_bound[4])) wedge3 = 3'd4;
    else wf3 = 1'b0;
    s = 7'(lay3) * 7'(NUM_WEDGES) + 7'(wedge3);
    layer3 = 3'(lay3);
    lfo3   = lf3;
    seg3   = (wf3 && lf3) ? s[5:0] : 6'd0;
    // loads give an all-zero result beat
    if (func3 == FUNC_LOAD) begin
      wedge3 = 3'd0;
      wf3    = 1'b0;
      layer3 = 3'd0;
      lfo3   = 1'b0;
      seg3   = 6'd0;
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wedge       <= wedge3;
      wedge_found <= wf3;
      layer       <= layer3;
      layer_found <= lfo3;
      segment     <= seg3;
    end
  end

endmodule
